[rtl/cqpos_pkg.sv]
// Package for the circular queue with positional operations.
// Holds the queue depth, request/result item structs and the op and status codes.
// No dependencies.
package cqpos_pkg;

  // Queue storage depth; one slot always stays empty. Power of two, so
  // ring indexes wrap by truncation.
  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = $clog2(DEPTH);

  localparam int unsigned KEY_W = 32;
  localparam int unsigned POS_W = 4;
  localparam int unsigned CNT_W = 4;

  typedef enum logic [1:0] {
    OP_APPEND  = 2'd0,
    OP_POP     = 2'd1,
    OP_INSERT  = 2'd2,
    OP_REMOVE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    op_e                      op;
    logic [POS_W-1:0]         position;
    logic signed [KEY_W-1:0]  key_in;
  } req_t;

  typedef struct packed {
    logic signed [KEY_W-1:0]  key_out;
    status_e                  status;
    logic [CNT_W-1:0]         count;
  } rsp_t;

endpackage

[rtl/circular_queue_with_positional_ops.sv]
// Circular queue of signed 32-bit keys with append, pop, insert-at and remove-at.
// Single module: sequencer, head/tail pointers and a 1W/1R entry memory.
// Depends on cqpos_pkg.
//
//  channel   ports               direction  handshake
//  -------   -----------------   ---------  ---------------------------------------
//  request   start, req_i        in         taken at an edge with start high, busy low
//  result    done_o, rsp_o       out        valid for the one cycle done_o is high
//
// Error cases go from acceptance straight to the result; append stores the key first,
// and pop reads the oldest key and waits for the registered read before the result.
// Insert at position p moves each entry from p on up one slot, working down from the
// newest; when it shifts, the key write waits for the last shift write on the single
// write port. Remove at p passes every shifted entry through the single memory read
// port, with the read of one entry overlapped with the write of the last.
// Reset leaves the queue empty (head and tail at DEPTH-1); entry storage is not
// cleared, no entry is read before it is written.
// busy stays high from acceptance until the result cycle; the receiver cannot stall,
// so the result is shown exactly once and the block goes back to idle.
module circular_queue_with_positional_ops (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  cqpos_pkg::req_t   req_i,
  output logic              busy,
  output logic              done_o,
  output cqpos_pkg::rsp_t   rsp_o
);

  localparam int unsigned IDX_W = cqpos_pkg::IDX_W;
  localparam int unsigned CNT_W = cqpos_pkg::CNT_W;
  localparam int unsigned POS_W = cqpos_pkg::POS_W;
  localparam int unsigned KEY_W = cqpos_pkg::KEY_W;
  localparam int unsigned DEPTH_ENTRIES = cqpos_pkg::DEPTH;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_APPEND = 7'b0000010,
    S_HEAD   = 7'b0000100,
    S_DRAIN  = 7'b0001000,
    S_INS    = 7'b0010000,
    S_REM    = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Ring pointers: head is the slot before the oldest key, tail the newest key.
  logic [IDX_W-1:0] head_q, head_d;
  logic [IDX_W-1:0] tail_q, tail_d;

  // Latched request and per-item bookkeeping.
  logic [POS_W-1:0]       pos_q, pos_d;
  logic [CNT_W-1:0]       n_q, n_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [KEY_W-1:0]       kin_q, kin_d;
  logic [KEY_W-1:0]       key_q, key_d;
  cqpos_pkg::status_e     status_q, status_d;

  // Pending write of the last read word, and capture of a removed key.
  logic                   wpend_q, wpend_d;
  logic [IDX_W-1:0]       wslot_q, wslot_d;
  logic                   cap_q, cap_d;

  // Entry memory ports.
  logic [KEY_W-1:0]       mem_q [DEPTH_ENTRIES];
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  logic [KEY_W-1:0]       mem_wdata;
  logic                   mem_re;
  logic [IDX_W-1:0]       mem_raddr;
  logic [KEY_W-1:0]       rdata_q;

  logic [CNT_W-1:0]       held;
  logic                   accept;

  // Storage slot of the entry at a position counted from the head.
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                               input logic [CNT_W-1:0] p);
    return IDX_W'(head + IDX_W'(1) + IDX_W'(p));
  endfunction

  assign held   = CNT_W'(IDX_W'(tail_q - head_q));
  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

  assign rsp_o.key_out = key_q;
  assign rsp_o.status  = status_q;
  assign rsp_o.count   = held;

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    tail_d   = tail_q;
    pos_d    = pos_q;
    n_d      = n_q;
    cnt_d    = cnt_q;
    kin_d    = kin_q;
    key_d    = cap_q ? rdata_q : key_q;
    status_d = status_q;
    wpend_d  = 1'b0;
    wslot_d  = wslot_q;
    cap_d    = 1'b0;

    // Retire a pending shift write whenever one is queued.
    mem_we    = wpend_q;
    mem_waddr = wslot_q;
    mem_wdata = rdata_q;
    mem_re    = 1'b0;
    mem_raddr = slot_of(head_q, cnt_q);

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          pos_d    = req_i.position;
          n_d      = held;
          kin_d    = req_i.key_in;
          key_d    = '1;
          status_d = cqpos_pkg::ST_OK;
          state_d  = S_DONE;
          unique case (req_i.op)
            cqpos_pkg::OP_APPEND: begin
              if (held >= CNT_W'(cqpos_pkg::DEPTH - 1)) begin
                status_d = cqpos_pkg::ST_FULL;
              end else begin
                state_d = S_APPEND;
              end
            end
            cqpos_pkg::OP_POP: begin
              if (held == '0) begin
                status_d = cqpos_pkg::ST_EMPTY;
              end else begin
                state_d = S_HEAD;
              end
            end
            cqpos_pkg::OP_INSERT: begin
              if (held >= CNT_W'(cqpos_pkg::DEPTH - 1)) begin
                status_d = cqpos_pkg::ST_FULL;
              end else if (CNT_W'(req_i.position) > held) begin
                status_d = cqpos_pkg::ST_RANGE;
              end else begin
                cnt_d   = held;
                state_d = S_INS;
              end
            end
            cqpos_pkg::OP_REMOVE: begin
              if (held == '0) begin
                status_d = cqpos_pkg::ST_EMPTY;
              end else if (CNT_W'(req_i.position) >= held) begin
                status_d = cqpos_pkg::ST_RANGE;
              end else begin
                cnt_d   = CNT_W'(req_i.position);
                state_d = S_REM;
              end
            end
            default: ;
          endcase
        end
      end

      S_APPEND: begin
        // Store at the slot after the tail and advance the tail.
        mem_we    = 1'b1;
        mem_waddr = IDX_W'(tail_q + IDX_W'(1));
        mem_wdata = kin_q;
        tail_d    = IDX_W'(tail_q + IDX_W'(1));
        state_d   = S_DONE;
      end

      S_HEAD: begin
        // Read the oldest key and advance the head.
        mem_re    = 1'b1;
        mem_raddr = slot_of(head_q, '0);
        cap_d     = 1'b1;
        head_d    = IDX_W'(head_q + IDX_W'(1));
        state_d   = S_DRAIN;
      end

      S_DRAIN: begin
        state_d = S_DONE;
      end

      S_INS: begin
        // Walk down from the count, moving each entry one slot up.
        if (cnt_q > CNT_W'(pos_q)) begin
          mem_re    = 1'b1;
          mem_raddr = slot_of(head_q, CNT_W'(cnt_q - CNT_W'(1)));
          wpend_d   = 1'b1;
          wslot_d   = slot_of(head_q, cnt_q);
          cnt_d     = CNT_W'(cnt_q - CNT_W'(1));
        end else if (!wpend_q) begin
          mem_we    = 1'b1;
          mem_waddr = slot_of(head_q, CNT_W'(pos_q));
          mem_wdata = kin_q;
          tail_d    = IDX_W'(tail_q + IDX_W'(1));
          state_d   = S_DONE;
        end
      end

      S_REM: begin
        // First read is the removed key; later reads move one slot down.
        if (cnt_q < n_q) begin
          mem_re    = 1'b1;
          mem_raddr = slot_of(head_q, cnt_q);
          cap_d     = (cnt_q == CNT_W'(pos_q));
          wpend_d   = (cnt_q != CNT_W'(pos_q));
          wslot_d   = slot_of(head_q, CNT_W'(cnt_q - CNT_W'(1)));
          cnt_d     = CNT_W'(cnt_q + CNT_W'(1));
        end else begin
          tail_d  = IDX_W'(tail_q - IDX_W'(1));
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= IDX_W'(cqpos_pkg::DEPTH - 1);
      tail_q  <= IDX_W'(cqpos_pkg::DEPTH - 1);
      wpend_q <= 1'b0;
      cap_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      wpend_q <= wpend_d;
      cap_q   <= cap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    n_q      <= n_d;
    cnt_q    <= cnt_d;
    kin_q    <= kin_d;
    key_q    <= key_d;
    status_q <= status_d;
    wslot_q  <= wslot_d;
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

endmodule
